@@ hw/rtl/odo_pkg.sv @@
// Shared types, constants and the Q16.16 saturation helper for the wheel odometry block.
// No dependencies; imported by every module under hw/rtl.
`default_nettype none

package odo_pkg;

    localparam int unsigned WINDOW_LENGTH_DEF = 8;
    localparam int unsigned FIFO_DEPTH_DEF    = 8;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned SUM_W     = 40;
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned PERIOD_W  = 16;
    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned S_TDATA_W = 8;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
    localparam logic [DATA_W-1:0]   SAT_MAX      = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]   SAT_MIN      = 32'h8000_0000;

    typedef enum logic [IDX_W-1:0] {
        REG_DIR_WHEEL1     = 3'd0,
        REG_DIR_WHEEL2     = 3'd1,
        REG_PERIOD_TICKS   = 3'd2,
        REG_DISTANCE_SCALE = 3'd3,
        REG_OMEGA_SCALE    = 3'd4,
        REG_VELOCITY_SCALE = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [DATA_W-1:0] velocity_scale;
        logic [DATA_W-1:0] omega_scale;
        logic [DATA_W-1:0] distance_scale;
    } odo_scales_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] speed;
        logic signed [DATA_W-1:0] omega;
        logic signed [DATA_W-1:0] distance;
    } wheel_result_t;

    typedef struct packed {
        wheel_result_t wheel2;
        wheel_result_t wheel1;
    } odo_result_t;

    localparam int unsigned M_TDATA_W = $bits(odo_result_t);

    function automatic logic [DATA_W-1:0] sat_q16(
        input logic              neg,
        input logic              hi_nz,
        input logic              scale_zero,
        input logic [PROD_W-1:0] prod
    );
        logic [DATA_W-1:0] r;
        if (scale_zero)
            r = '0;
        else if (hi_nz)
            r = neg ? SAT_MIN : SAT_MAX;
        else if (neg)
            r = (prod >= {{(PROD_W-DATA_W){1'b0}}, SAT_MIN}) ? SAT_MIN
                : (DATA_W'(0) - prod[DATA_W-1:0]);
        else
            r = (prod > {{(PROD_W-DATA_W){1'b0}}, SAT_MAX}) ? SAT_MAX : prod[DATA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/odo_wheel.sv @@
// One wheel's update datapath: delta, moving-average window, magnitude split and scaled products.
// Depends on odo_pkg.
`default_nettype none

module odo_wheel
    import odo_pkg::*;
#(
    parameter int unsigned WINDOW_LENGTH = WINDOW_LENGTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     update,
    input  wire logic signed [DATA_W-1:0] count,
    input  wire odo_scales_t              scales,
    output wheel_result_t                 result
);

    logic signed [DATA_W-1:0] last_count_reg;
    logic signed [DATA_W-1:0] window_reg [WINDOW_LENGTH];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DATA_W-1:0] delta;
    logic signed [SUM_W-1:0]  sum_next;

    logic signed [DATA_W-1:0] p2_count_reg;
    logic signed [SUM_W-1:0]  p2_sum_reg;

    logic                     p3_dist_neg_reg;
    logic [DATA_W-1:0]        p3_dist_mag_reg;
    logic                     p3_sum_neg_reg;
    logic                     p3_sum_hi_reg;
    logic [DATA_W-1:0]        p3_sum_mag_reg;
    logic [SUM_W-1:0]         sum_mag;
    logic [DATA_W-1:0]        dist_mag;

    logic                     p4_dist_neg_reg;
    logic                     p4_sum_neg_reg;
    logic                     p4_sum_hi_reg;
    logic                     p4_dist_zero_reg;
    logic                     p4_omega_zero_reg;
    logic                     p4_speed_zero_reg;
    logic [PROD_W-1:0]        p4_dist_prod_reg;
    logic [PROD_W-1:0]        p4_omega_prod_reg;
    logic [PROD_W-1:0]        p4_speed_prod_reg;

    assign delta    = count - last_count_reg;
    assign sum_next = sum_reg - SUM_W'(window_reg[WINDOW_LENGTH-1]) + SUM_W'(delta);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            sum_reg        <= '0;
            for (int i = 0; i < WINDOW_LENGTH; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (update)
        begin
            last_count_reg <= count;
            sum_reg        <= sum_next;
            window_reg[0]  <= delta;
            for (int i = 1; i < WINDOW_LENGTH; i++)
            begin
                window_reg[i] <= window_reg[i-1];
            end
        end
    end

    assign sum_mag  = p2_sum_reg[SUM_W-1] ? (SUM_W'(0) - p2_sum_reg) : p2_sum_reg;
    assign dist_mag = p2_count_reg[DATA_W-1] ? (DATA_W'(0) - p2_count_reg) : p2_count_reg;

    always_ff @(posedge clk)
    begin
        p2_count_reg <= count;
        p2_sum_reg   <= sum_next;

        p3_dist_neg_reg <= p2_count_reg[DATA_W-1];
        p3_dist_mag_reg <= dist_mag;
        p3_sum_neg_reg  <= p2_sum_reg[SUM_W-1];
        p3_sum_hi_reg   <= |sum_mag[SUM_W-1:DATA_W];
        p3_sum_mag_reg  <= sum_mag[DATA_W-1:0];

        p4_dist_neg_reg   <= p3_dist_neg_reg;
        p4_sum_neg_reg    <= p3_sum_neg_reg;
        p4_sum_hi_reg     <= p3_sum_hi_reg;
        p4_dist_zero_reg  <= (scales.distance_scale == '0);
        p4_omega_zero_reg <= (scales.omega_scale == '0);
        p4_speed_zero_reg <= (scales.velocity_scale == '0);
        p4_dist_prod_reg  <= PROD_W'(p3_dist_mag_reg) * PROD_W'(scales.distance_scale);
        p4_omega_prod_reg <= PROD_W'(p3_sum_mag_reg) * PROD_W'(scales.omega_scale);
        p4_speed_prod_reg <= PROD_W'(p3_sum_mag_reg) * PROD_W'(scales.velocity_scale);
    end

    always_comb
    begin
        result.distance = sat_q16(p4_dist_neg_reg, 1'b0, p4_dist_zero_reg, p4_dist_prod_reg);
        result.omega    = sat_q16(p4_sum_neg_reg, p4_sum_hi_reg, p4_omega_zero_reg,
                                  p4_omega_prod_reg);
        result.speed    = sat_q16(p4_sum_neg_reg, p4_sum_hi_reg, p4_speed_zero_reg,
                                  p4_speed_prod_reg);
    end

endmodule

`default_nettype wire

@@ hw/rtl/odo_fifo.sv @@
// Result queue in front of the output stream; absorbs results while the consumer stalls.
// Depends on odo_pkg.
`default_nettype none

module odo_fifo
    import odo_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    input  wire odo_result_t                       push_data,
    input  wire logic                              pop,
    output odo_result_t                            head,
    output logic                                   not_empty,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]        fill
);

    localparam int unsigned PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(FIFO_DEPTH+1);

    odo_result_t       store_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH-1)) ? '0 : (p + PTR_W'(1));
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                fill_reg <= fill_reg + FILL_W'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - FILL_W'(1);
        end
    end

    assign head      = store_reg[rd_ptr_reg];
    assign not_empty = (fill_reg != '0);
    assign fill      = fill_reg;

endmodule

`default_nettype wire

@@ hw/rtl/wheel_odometry_moving_average_top.sv @@
// Two-wheel odometry with moving-average rate and speed: edge counting, update timer, result queue.
// Depends on odo_pkg, odo_wheel and odo_fifo.
//
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------------------
// sample   | s_axis_tvalid/s_axis_tready | s_axis_tdata: edge_wheel1, edge_wheel2, tick
// result   | m_axis_tvalid/m_axis_tready | m_axis_tdata: six signed Q16.16 words
// config   | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// One sample is taken per cycle while s_axis_tready is high; counts and the update timer change at the accepting edge.
// A result reaches m_axis through a four-stage product pipe and then the result queue.
// s_axis_tready drops only when the result queue plus results in flight would fill the queue.
// Reset clears counts, windows, sums and the timer at once; no clearing pass.
`default_nettype none

module wheel_odometry_moving_average_top
    import odo_pkg::*;
#(
    parameter int unsigned WINDOW_LENGTH = WINDOW_LENGTH_DEF,
    parameter int unsigned FIFO_DEPTH    = FIFO_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // edge_wheel1, edge_wheel2, tick, zero pad
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,  // distance1, omega1, speed1,
                                                     // distance2, omega2, speed2
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [IDX_W-1:0]     cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    localparam int unsigned FILL_W   = $clog2(FIFO_DEPTH+1);
    localparam int unsigned CREDIT_W = $clog2(FIFO_DEPTH+5);

    logic                  dir_wheel1_reg;
    logic                  dir_wheel2_reg;
    logic [PERIOD_W-1:0]   period_reg;
    odo_scales_t           scales_reg;

    logic signed [DATA_W-1:0] count1_reg;
    logic signed [DATA_W-1:0] count2_reg;
    logic signed [DATA_W-1:0] count1_next;
    logic signed [DATA_W-1:0] count2_next;
    logic [ELAPSED_W-1:0]     elapsed_reg;
    logic [ELAPSED_W-1:0]     elapsed_inc;
    logic [ELAPSED_W-1:0]     elapsed_next;
    logic                     fire;
    logic                     accept;
    logic                     edge1;
    logic                     edge2;
    logic                     tick;

    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic                     v4_reg;
    logic signed [DATA_W-1:0] p1_count1_reg;
    logic signed [DATA_W-1:0] p1_count2_reg;

    odo_result_t              result;
    odo_result_t              head;
    logic                     not_empty;
    logic [FILL_W-1:0]        fill;
    logic [CREDIT_W-1:0]      credit;
    logic                     pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_wheel1_reg <= 1'b1;
            dir_wheel2_reg <= 1'b1;
            period_reg     <= PERIOD_RESET;
            scales_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DIR_WHEEL1:     dir_wheel1_reg            <= cfg_data[0];
                REG_DIR_WHEEL2:     dir_wheel2_reg            <= cfg_data[0];
                REG_PERIOD_TICKS:   period_reg                <= cfg_data[PERIOD_W-1:0];
                REG_DISTANCE_SCALE: scales_reg.distance_scale <= cfg_data;
                REG_OMEGA_SCALE:    scales_reg.omega_scale    <= cfg_data;
                REG_VELOCITY_SCALE: scales_reg.velocity_scale <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign edge1  = s_axis_tdata[0];
    assign edge2  = s_axis_tdata[1];
    assign tick   = s_axis_tdata[2];
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        count1_next = count1_reg;
        count2_next = count2_reg;
        if (edge1)
            count1_next = dir_wheel1_reg ? (count1_reg + DATA_W'(1)) : (count1_reg - DATA_W'(1));
        if (edge2)
            count2_next = dir_wheel2_reg ? (count2_reg + DATA_W'(1)) : (count2_reg - DATA_W'(1));
        elapsed_inc  = elapsed_reg + ELAPSED_W'(1);
        fire         = tick && (elapsed_inc > ELAPSED_W'(period_reg));
        elapsed_next = elapsed_reg;
        if (fire)
            elapsed_next = '0;
        else if (tick)
            elapsed_next = elapsed_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count1_reg  <= '0;
            count2_reg  <= '0;
            elapsed_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count1_reg  <= count1_next;
                count2_reg  <= count2_next;
                elapsed_reg <= elapsed_next;
            end
            v1_reg <= accept && fire;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_count1_reg <= count1_next;
        p1_count2_reg <= count2_next;
    end

    odo_wheel #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_wheel1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (v1_reg),
        .count  (p1_count1_reg),
        .scales (scales_reg),
        .result (result.wheel1)
    );

    odo_wheel #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_wheel2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (v1_reg),
        .count  (p1_count2_reg),
        .scales (scales_reg),
        .result (result.wheel2)
    );

    assign pop = m_axis_tvalid && m_axis_tready;

    odo_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (v4_reg),
        .push_data (result),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .fill      (fill)
    );

    assign credit = CREDIT_W'(fill) + CREDIT_W'(v1_reg) + CREDIT_W'(v2_reg)
                  + CREDIT_W'(v3_reg) + CREDIT_W'(v4_reg);

    assign s_axis_tready = (credit < CREDIT_W'(FIFO_DEPTH));
    assign m_axis_tvalid = not_empty;
    assign m_axis_tdata  = head;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !pop |-> fill < FILL_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit <= CREDIT_W'(FIFO_DEPTH))
        else $error("results in flight exceed queue space");

    a_fire_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        accept && fire |=> v1_reg && elapsed_reg == '0)
        else $error("update did not enter pipe or timer not cleared");

    a_timer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        elapsed_reg <= ELAPSED_W'(65536))
        else $error("update timer out of range");
`endif

endmodule

`default_nettype wire
